>>> src/cet_pkg.sv
// Package for the cubic ease trajectory core.
// Holds the format constants, the route codes and the beat structs.
// No dependencies.
`default_nettype none

package cet_pkg;

    localparam int TIME_BITS = 32;
    localparam int POS_BITS  = 32;
    localparam int FRAC_BITS = 16;

    localparam logic [FRAC_BITS:0] ONE_Q  = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] HALF_Q = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

    // Route of one beat: hold start, hold end, or ease between them
    typedef enum logic [1:0] {
        SEL_FROM,
        SEL_TO,
        SEL_EASE
    } sel_t;

    // Beat carried through the divider cells
    typedef struct packed {
        logic                        valid;
        sel_t                        sel;
        logic                        done;
        logic [TIME_BITS-1:0]        rem;
        logic [TIME_BITS-1:0]        den;
        logic [FRAC_BITS:0]          q;
        logic signed [POS_BITS-1:0]  from_pos;
        logic signed [POS_BITS-1:0]  to_pos;
    } div_beat_t;

    // Beat leaving the easing stages
    typedef struct packed {
        logic                        valid;
        sel_t                        sel;
        logic [FRAC_BITS:0]          e;
        logic signed [POS_BITS-1:0]  from_pos;
        logic signed [POS_BITS-1:0]  to_pos;
    } ease_beat_t;

endpackage

`default_nettype wire

>>> src/cubic_ease_trajectory_core.sv
// Top level of the cubic ease trajectory core.
// Depends on cet_pkg, cet_div_cell, cet_ease and cet_scale.
`default_nettype none

// Setpoint generator: one position beat in, one eased position beat out. A new
// beat is taken every cycle while the pipe is not held; each beat passes the entry
// register, the row of divider cells, one quotient bit per cell, and then the cube
// and scaling stages. The whole pipe holds only while a finished result waits at
// the output with out_stall high.
module cubic_ease_trajectory_core
    import cet_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [TIME_BITS-1:0]       now_time,
    input  wire logic [TIME_BITS-1:0]       move_start_time,
    input  wire logic [TIME_BITS-1:0]       move_end_time,
    input  wire logic signed [POS_BITS-1:0] from_position,
    input  wire logic signed [POS_BITS-1:0] to_position,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [POS_BITS-1:0]      eased_position
);

    logic       adv;
    div_beat_t  entry_reg;
    div_beat_t  entry_next;
    div_beat_t  chain [0:FRAC_BITS];
    ease_beat_t eased;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Classify the window and seed the divider
    always_comb
    begin
        entry_next.valid    = in_valid;
        entry_next.rem      = now_time - move_start_time;
        entry_next.den      = move_end_time - move_start_time;
        entry_next.from_pos = from_position;
        entry_next.to_pos   = to_position;
        entry_next.done     = now_time == move_end_time;
        entry_next.q        = entry_next.done ? ONE_Q : '0;
        if (now_time < move_start_time)
            entry_next.sel = SEL_FROM;
        else if (now_time > move_end_time || move_end_time <= move_start_time)
            entry_next.sel = SEL_TO;
        else
            entry_next.sel = SEL_EASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else if (adv)
            entry_reg <= entry_next;
    end

    assign chain[0] = entry_reg;

    // Row of divider cells
    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        cet_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    cet_ease u_ease (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .beat_in  (chain[FRAC_BITS]),
        .beat_out (eased)
    );

    cet_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .beat_in   (eased),
        .res_valid (out_valid),
        .res_pos   (eased_position)
    );

endmodule

`default_nettype wire

>>> src/cet_div_cell.sv
// One cell of the progress divider: one restoring quotient bit per cycle while the pipe advances.
// Depends on cet_pkg.
`default_nettype none

module cet_div_cell
    import cet_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      adv,
    input  div_beat_t      beat_in,
    output div_beat_t      beat_out
);

    div_beat_t beat_reg;
    div_beat_t beat_next;

    // Shift, trial-subtract and record one quotient bit
    always_comb
    begin
        logic [TIME_BITS:0] rem2;
        logic               qbit;
        beat_next = beat_in;
        rem2      = {beat_in.rem, 1'b0};
        qbit      = 1'b0;
        if (beat_in.sel == SEL_EASE && !beat_in.done)
        begin
            if (rem2 >= {1'b0, beat_in.den})
            begin
                rem2 = rem2 - {1'b0, beat_in.den};
                qbit = 1'b1;
            end
            beat_next.rem = rem2[TIME_BITS-1:0];
            beat_next.q   = {beat_in.q[FRAC_BITS-1:0], qbit};
        end
    end

    // Advance the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else if (adv)
            beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

`default_nettype wire

>>> src/cet_ease.sv
// Cubic ease-in-out of the progress in two registered stages.
// Depends on cet_pkg.
`default_nettype none

module cet_ease
    import cet_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  div_beat_t  beat_in,
    output ease_beat_t beat_out
);

    logic                       valid_reg;
    sel_t                       sel_reg;
    logic                       lower_reg;
    logic [FRAC_BITS:0]         u_reg;
    logic [FRAC_BITS:0]         sq_reg;
    logic signed [POS_BITS-1:0] from_reg;
    logic signed [POS_BITS-1:0] to_reg;

    logic                       lower_next;
    logic [FRAC_BITS:0]         u_next;
    logic [2*FRAC_BITS+1:0]     sq_full;

    ease_beat_t                 out_reg;
    ease_beat_t                 out_next;
    logic [2*FRAC_BITS+1:0]     cube_full;
    logic [FRAC_BITS:0]         cube;

    // Fold the upper half onto |2t-2| and square
    always_comb
    begin
        logic [FRAC_BITS+1:0] m;
        lower_next = beat_in.q < HALF_Q;
        m = {ONE_Q, 1'b0} - {beat_in.q, 1'b0};
        u_next  = lower_next ? beat_in.q : m[FRAC_BITS:0];
        sq_full = u_next * u_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= beat_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_reg   <= beat_in.sel;
            lower_reg <= lower_next;
            u_reg     <= u_next;
            sq_reg    <= sq_full[2*FRAC_BITS:FRAC_BITS];
            from_reg  <= beat_in.from_pos;
            to_reg    <= beat_in.to_pos;
        end
    end

    // Cube, then scale by four or take one minus half the cube
    always_comb
    begin
        cube_full         = sq_reg * u_reg;
        cube              = cube_full[2*FRAC_BITS:FRAC_BITS];
        out_next.valid    = valid_reg;
        out_next.sel      = sel_reg;
        out_next.from_pos = from_reg;
        out_next.to_pos   = to_reg;
        out_next.e        = lower_reg ? {cube[FRAC_BITS-2:0], 2'b00}
                                      : ONE_Q - {1'b0, cube[FRAC_BITS:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (adv)
            out_reg <= out_next;
    end

    assign beat_out = out_reg;

endmodule

`default_nettype wire

>>> src/cet_scale.sv
// Scales the signed distance by the eased fraction and forms the result.
// Depends on cet_pkg.
`default_nettype none

module cet_scale
    import cet_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  ease_beat_t                 beat_in,
    output logic                       res_valid,
    output logic signed [POS_BITS-1:0] res_pos
);

    localparam int HI_BITS = POS_BITS + 1 - FRAC_BITS;

    // Stage one: magnitude of the distance
    logic                       v1_reg;
    sel_t                       sel1_reg;
    logic                       neg1_reg;
    logic [POS_BITS:0]          mag1_reg;
    logic [FRAC_BITS:0]         e1_reg;
    logic signed [POS_BITS-1:0] from1_reg;
    logic signed [POS_BITS-1:0] to1_reg;

    logic signed [POS_BITS:0]   diff;
    logic [POS_BITS:0]          mag_next;

    // Stage two: offset
    logic                       v2_reg;
    sel_t                       sel2_reg;
    logic                       neg2_reg;
    logic [POS_BITS:0]          off2_reg;
    logic signed [POS_BITS-1:0] from2_reg;
    logic signed [POS_BITS-1:0] to2_reg;

    logic [HI_BITS+FRAC_BITS:0] hi_prod;
    logic [2*FRAC_BITS:0]       lo_prod;
    logic [POS_BITS:0]          off_next;

    // Output register
    logic                       v3_reg;
    logic signed [POS_BITS-1:0] res_reg;
    logic signed [POS_BITS-1:0] res_next;

    always_comb
    begin
        diff     = {beat_in.to_pos[POS_BITS-1], beat_in.to_pos}
                 - {beat_in.from_pos[POS_BITS-1], beat_in.from_pos};
        mag_next = diff[POS_BITS] ? (POS_BITS+1)'(-diff) : (POS_BITS+1)'(diff);
    end

    // Split the magnitude so each product stays narrow
    always_comb
    begin
        hi_prod  = mag1_reg[POS_BITS:FRAC_BITS] * e1_reg;
        lo_prod  = mag1_reg[FRAC_BITS-1:0] * e1_reg;
        off_next = hi_prod[POS_BITS:0]
                 + (POS_BITS+1)'(lo_prod[2*FRAC_BITS:FRAC_BITS]);
    end

    // Pick the route and apply the offset
    always_comb
    begin
        logic [POS_BITS:0] sum;
        sum = neg2_reg ? {from2_reg[POS_BITS-1], from2_reg} - off2_reg
                       : {from2_reg[POS_BITS-1], from2_reg} + off2_reg;
        case (sel2_reg)
            SEL_FROM: res_next = from2_reg;
            SEL_TO:   res_next = to2_reg;
            SEL_EASE: res_next = sum[POS_BITS-1:0];
            default:  res_next = to2_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= beat_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel1_reg  <= beat_in.sel;
            neg1_reg  <= diff[POS_BITS];
            mag1_reg  <= mag_next;
            e1_reg    <= beat_in.e;
            from1_reg <= beat_in.from_pos;
            to1_reg   <= beat_in.to_pos;
            sel2_reg  <= sel1_reg;
            neg2_reg  <= neg1_reg;
            off2_reg  <= off_next;
            from2_reg <= from1_reg;
            to2_reg   <= to1_reg;
            res_reg   <= res_next;
        end
    end

    assign res_valid = v3_reg;
    assign res_pos   = res_reg;

endmodule

`default_nettype wire
